@@ rtl/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types, constants and calendar tables of the date serial and
// difference unit.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int MAX_YEAR   = 9999;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int DOY_W      = 9;
    localparam int SERIAL_W   = 22;
    localparam int DIFF_W     = 23;

    // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for y < 43690
    localparam int RECIP_100   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int QUO_W       = 8;    // year / 100 for any 14-bit year
    localparam int PQ_W        = 7;    // (year - 1) / 100 for a valid year

    localparam int DAYS_PER_YEAR = 365;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // One classified date, ready for the serial computation
    typedef struct packed {
        logic              valid;
        logic [DOY_W-1:0]  doy;
        logic [YEAR_W-1:0] prev;     // year - 1
        logic [PQ_W-1:0]   prev_q;   // (year - 1) / 100
    } date_info_t;

    typedef struct packed {
        date_info_t first;
        date_info_t second;
    } dsd_item_t;

    function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [YEAR_W+RECIP_W-1:0] p;
        p = (YEAR_W+RECIP_W)'(y) * (YEAR_W+RECIP_W)'(RECIP_100);
        return QUO_W'(p >> RECIP_SHIFT);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    r = DAY_W'(30);
            4'd2:                                       r = DAY_W'(28);
            default:                                    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        unique case (m)
            4'd1:    r = DOY_W'(0);
            4'd2:    r = DOY_W'(31);
            4'd3:    r = DOY_W'(59);
            4'd4:    r = DOY_W'(90);
            4'd5:    r = DOY_W'(120);
            4'd6:    r = DOY_W'(151);
            4'd7:    r = DOY_W'(181);
            4'd8:    r = DOY_W'(212);
            4'd9:    r = DOY_W'(243);
            4'd10:   r = DOY_W'(273);
            4'd11:   r = DOY_W'(304);
            4'd12:   r = DOY_W'(334);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/dsd_if.sv @@
// ----------------------------------------------------------------------------
// dsd_in_if / dsd_out_if
// Valid/ready channels of the date serial and difference unit.
// ----------------------------------------------------------------------------
interface dsd_in_if;
    import dsd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );
    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );
endinterface

interface dsd_out_if;
    import dsd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     first_valid;
    logic                     second_valid;
    logic [DOY_W-1:0]         first_day_of_year;
    logic [SERIAL_W-1:0]      first_serial;
    logic [SERIAL_W-1:0]      second_serial;
    logic signed [DIFF_W-1:0] day_difference;
    logic                     first_is_later;

    modport source (
        output valid, first_valid, second_valid, first_day_of_year,
               first_serial, second_serial, day_difference, first_is_later,
        input  ready
    );
    modport sink (
        input  valid, first_valid, second_valid, first_day_of_year,
               first_serial, second_serial, day_difference, first_is_later,
        output ready
    );
endinterface

@@ rtl/dsd_front.sv @@
// ----------------------------------------------------------------------------
// dsd_front
// Accepts date pairs, divides the years by 100, then checks each date and
// forms its day of year before pushing it into the queue.
// ----------------------------------------------------------------------------
module dsd_front (
    input  logic              clk,
    input  logic              rst_n,
    dsd_in_if.sink            dates,
    input  logic              full,
    output logic              push,
    output dsd_pkg::dsd_item_t push_item
);
    import dsd_pkg::*;

    logic              f1_valid_reg;
    logic              f1_valid_next;
    date_t             f1_a_reg;
    date_t             f1_b_reg;
    logic [QUO_W-1:0]  f1_qa_reg;
    logic [QUO_W-1:0]  f1_qb_reg;
    logic              accept;

    function automatic date_info_t classify(input date_t d, input logic [QUO_W-1:0] q);
        date_info_t             r;
        logic                   yr_ok;
        logic                   mo_ok;
        logic                   day_ok;
        logic                   cent;
        logic                   leap;
        logic [YEAR_W:0]        q_x100;
        logic [DAY_W:0]         lim;
        logic [QUO_W-1:0]       pq;
        yr_ok  = (d.year != '0) && (int'(d.year) <= MAX_YEAR);
        mo_ok  = (d.month >= MONTH_JAN) && (d.month <= MONTH_DEC);
        q_x100 = (YEAR_W+1)'(q) * (YEAR_W+1)'(100);
        cent   = (q_x100 == (YEAR_W+1)'(d.year));
        leap   = (d.year[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
        lim    = (DAY_W+1)'(month_len(d.month))
               + (DAY_W+1)'(leap && (d.month == MONTH_FEB));
        day_ok = (d.day != '0) && ((DAY_W+1)'(d.day) <= lim);
        pq     = q - QUO_W'(cent);
        r.valid  = yr_ok && mo_ok && day_ok;
        r.doy    = days_before(d.month) + DOY_W'(d.day)
                 + DOY_W'(leap && (d.month > MONTH_FEB));
        r.prev   = d.year - YEAR_W'(1);
        r.prev_q = pq[PQ_W-1:0];
        return r;
    endfunction

    assign dates.ready = !f1_valid_reg || !full;
    assign accept      = dates.valid && dates.ready;
    assign push        = f1_valid_reg && !full;

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
            f1_valid_next = 1'b1;
        else if (push)
            f1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= f1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_a_reg  <= '{day: dates.first_day, month: dates.first_month,
                           year: dates.first_year};
            f1_b_reg  <= '{day: dates.second_day, month: dates.second_month,
                           year: dates.second_year};
            f1_qa_reg <= div100(dates.first_year);
            f1_qb_reg <= div100(dates.second_year);
        end
    end

    assign push_item.first  = classify(f1_a_reg, f1_qa_reg);
    assign push_item.second = classify(f1_b_reg, f1_qb_reg);

endmodule

@@ rtl/dsd_queue.sv @@
// ----------------------------------------------------------------------------
// dsd_queue
// Short queue between the front and the back end.
// ----------------------------------------------------------------------------
module dsd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dsd_pkg::dsd_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               nonempty,
    output dsd_pkg::dsd_item_t head
);
    import dsd_pkg::*;

    dsd_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("pop from empty queue");

endmodule

@@ rtl/dsd_back.sv @@
// ----------------------------------------------------------------------------
// dsd_back
// Turns classified dates into day numbers, then forms the difference and
// the ordering flag in the output register.
// ----------------------------------------------------------------------------
module dsd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               nonempty,
    input  dsd_pkg::dsd_item_t head,
    output logic               pop,
    dsd_out_if.source          result
);
    import dsd_pkg::*;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_va_reg;
    logic                     s1_vb_reg;
    logic [DOY_W-1:0]         s1_doy_reg;
    logic [SERIAL_W-1:0]      s1_sa_reg;
    logic [SERIAL_W-1:0]      s1_sb_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_va_reg;
    logic                     out_vb_reg;
    logic [DOY_W-1:0]         out_doy_reg;
    logic [SERIAL_W-1:0]      out_sa_reg;
    logic [SERIAL_W-1:0]      out_sb_reg;
    logic signed [DIFF_W-1:0] out_diff_reg;
    logic                     out_later_reg;

    logic                     out_adv;
    logic                     s1_adv;
    logic                     both_ok;
    logic signed [DIFF_W-1:0] diff;

    // prev*365 + prev/4 - prev/100 + prev/400 + doy, zero when invalid
    function automatic logic [SERIAL_W-1:0] serial(input date_info_t d);
        logic [SERIAL_W-1:0] s;
        s = SERIAL_W'(d.prev) * SERIAL_W'(DAYS_PER_YEAR)
          + SERIAL_W'(d.prev >> 2)
          + SERIAL_W'(d.prev_q >> 2)
          + SERIAL_W'(d.doy)
          - SERIAL_W'(d.prev_q);
        return d.valid ? s : '0;
    endfunction

    assign out_adv = !out_valid_reg || result.ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign pop     = nonempty && s1_adv;

    assign both_ok = s1_va_reg && s1_vb_reg;
    assign diff    = both_ok ? (signed'({1'b0, s1_sb_reg}) - signed'({1'b0, s1_sa_reg}))
                             : '0;

    always_comb
    begin
        s1_valid_next  = s1_adv ? nonempty : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_va_reg  <= head.first.valid;
            s1_vb_reg  <= head.second.valid;
            s1_doy_reg <= head.first.valid ? head.first.doy : '0;
            s1_sa_reg  <= serial(head.first);
            s1_sb_reg  <= serial(head.second);
        end
        if (out_adv && s1_valid_reg)
        begin
            out_va_reg    <= s1_va_reg;
            out_vb_reg    <= s1_vb_reg;
            out_doy_reg   <= s1_doy_reg;
            out_sa_reg    <= s1_sa_reg;
            out_sb_reg    <= s1_sb_reg;
            out_diff_reg  <= diff;
            out_later_reg <= both_ok && (s1_sa_reg > s1_sb_reg);
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.first_valid       = out_va_reg;
    assign result.second_valid      = out_vb_reg;
    assign result.first_day_of_year = out_doy_reg;
    assign result.first_serial      = out_sa_reg;
    assign result.second_serial     = out_sb_reg;
    assign result.day_difference    = out_diff_reg;
    assign result.first_is_later    = out_later_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_va_reg) |-> (out_sa_reg == '0 && out_doy_reg == '0))
        else $error("invalid first date with nonzero numbers");

    a_diff_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (!out_va_reg || !out_vb_reg))
            |-> (out_diff_reg == '0 && !out_later_reg))
        else $error("difference not cleared for invalid date");

    a_later_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_later_reg) |-> out_diff_reg[DIFF_W-1])
        else $error("later flag disagrees with difference sign");

endmodule

@@ rtl/date_serial_and_difference_unit.sv @@
// ----------------------------------------------------------------------------
// date_serial_and_difference_unit
// Checks two Gregorian dates and gives their day numbers and difference.
// ----------------------------------------------------------------------------
// Usage:
//   dates  : one request carries two dates (day, month, year). It is taken
//            at a clock edge with valid and ready both high.
//   result : one response per request, in order: validity flags, day of year
//            of the first date, both day numbers (1/1/1 is day 1), the
//            difference second minus first and a first-is-later flag.
//            Numbers of an invalid date, and the difference, read as zero.
// Path: from acceptance through the year division register, classification into the
//   queue, the day-number register and the output register to result valid.
// Throughput: one request per cycle while result.ready is high; the year / 100 multiply, the day-number
//   multiply-add and the difference subtract each sit in a stage of their own.
// Stall: when result.ready is low the output register holds; the back end
//   fills, then the two-entry queue, then the front register, and only then
//   dates.ready drops. Throughput recovers at once when ready returns.
// Reset: rst_n clears the queue and all valid flags; requests in flight are dropped, none is
//   invented, and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module date_serial_and_difference_unit (
    input  logic      clk,
    input  logic      rst_n,
    dsd_in_if.sink    dates,
    dsd_out_if.source result
);
    import dsd_pkg::*;

    logic      push;
    logic      full;
    logic      pop;
    logic      nonempty;
    dsd_item_t push_item;
    dsd_item_t head;

    dsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .dates     (dates),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    dsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .head      (head)
    );

    dsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .nonempty (nonempty),
        .head     (head),
        .pop      (pop),
        .result   (result)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Date serial and difference unit testbench. Date pairs are pushed through
// the dates channel with random idle gaps, and every response is compared
// field by field with numbers worked out by a local calendar model. The
// traffic covers directed corner dates, random valid and malformed pairs,
// century leap years, back-to-back runs and long result stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsd_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int MAX_WAIT     = 17;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic                     first_valid;
        logic                     second_valid;
        logic [DOY_W-1:0]         doy;
        logic [SERIAL_W-1:0]      first_serial;
        logic [SERIAL_W-1:0]      second_serial;
        logic signed [DIFF_W-1:0] diff;
        logic                     first_later;
    } date_numbers_t;

    logic clk;
    logic rst_n;

    dsd_in_if  dates_ch ();
    dsd_out_if result_ch ();

    date_serial_and_difference_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .dates  (dates_ch),
        .result (result_ch)
    );

    date_numbers_t pending_numbers [$];

    int error_count        = 0;
    int request_count      = 0;
    int result_count       = 0;
    int both_valid_count   = 0;
    int first_later_count  = 0;
    int invalid_count      = 0;
    int hold_count         = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------
    function automatic bit is_leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // 0 for a month outside 1..12
    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            MONTH_FEB:             n = is_leap_year(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    function automatic bit score_date(input date_t dt, output int unsigned doy,
                                      output int unsigned serial);
        int unsigned y, m, d, prev, k;
        y      = dt.year;
        m      = dt.month;
        d      = dt.day;
        doy    = 0;
        serial = 0;
        if (y < 1 || y > MAX_YEAR)
            return 1'b0;
        if (d < 1 || d > days_in_month(m, y))
            return 1'b0;
        // the leap day falls into the sum once February is passed
        doy = d;
        for (k = 1; k < m; k++)
            doy += days_in_month(k, y);
        prev   = y - 1;
        serial = prev * DAYS_PER_YEAR + prev / 4 - prev / 100 + prev / 400 + doy;
        return 1'b1;
    endfunction

    function automatic date_numbers_t predict_numbers(date_t a, date_t b);
        date_numbers_t r;
        int unsigned   doy_a, ser_a, doy_b, ser_b;
        r               = '0;
        r.first_valid   = score_date(a, doy_a, ser_a);
        r.second_valid  = score_date(b, doy_b, ser_b);
        r.doy           = DOY_W'(doy_a);
        r.first_serial  = SERIAL_W'(ser_a);
        r.second_serial = SERIAL_W'(ser_b);
        if (r.first_valid && r.second_valid)
        begin
            r.diff        = DIFF_W'(int'(ser_b) - int'(ser_a));
            r.first_later = (ser_a > ser_b);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic date_t mk_date(int unsigned d, int unsigned m, int unsigned y);
        date_t dt;
        dt.day   = DAY_W'(d);
        dt.month = MONTH_W'(m);
        dt.year  = YEAR_W'(y);
        return dt;
    endfunction

    // mostly real dates; now and then, and always when loose is set, any bit pattern
    function automatic date_t draw_date(bit loose);
        int unsigned y, m, d;
        if (loose || $urandom_range(0, 9) == 0)
            return mk_date($urandom_range(0, 31), $urandom_range(0, 15),
                           $urandom_range(0, 16383));
        case ($urandom_range(0, 5))
            0:       y = $urandom_range(1, 12);
            1:       y = MAX_YEAR - $urandom_range(0, 12);
            2:       y = 100 * $urandom_range(1, 99);
            default: y = $urandom_range(1, MAX_YEAR);
        endcase
        m = $urandom_range(1, 12);
        d = $urandom_range(1, days_in_month(m, y));
        return mk_date(d, m, y);
    endfunction

    // second date of a pair, often close to the first
    function automatic date_t draw_partner(date_t a);
        date_t b;
        b = a;
        case ($urandom_range(0, 7))
            0: ;
            1, 2: b.day = DAY_W'($urandom_range(1, 31));
            3: b.year = a.year + YEAR_W'($urandom_range(0, 1) ? 1 : -1);
            4: b.month = MONTH_W'($urandom_range(1, 12));
            default: b = draw_date(1'b0);
        endcase
        return b;
    endfunction

    function automatic int draw_gap(bit idle);
        return idle ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: holds the pair until accepted, then idles a while
    // ------------------------------------------------------------------------
    task automatic send_dates(date_t a, date_t b);
        int gap;
        dates_ch.valid        <= 1'b1;
        dates_ch.first_day    <= a.day;
        dates_ch.first_month  <= a.month;
        dates_ch.first_year   <= a.year;
        dates_ch.second_day   <= b.day;
        dates_ch.second_month <= b.month;
        dates_ch.second_year  <= b.year;
        do
            @(posedge clk);
        while (!dates_ch.ready);
        pending_numbers.push_back(predict_numbers(a, b));
        request_count++;
        gap = draw_gap(tx_idle);
        if (gap > 0)
        begin
            dates_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready gaps, plus long holds on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_count++;
                gap = HOLD_CYCLES;
            end
            else
                gap = draw_gap(rx_idle);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   result_count, name, $signed(got), $signed(want)));
    endtask

    always @(posedge clk)
    begin : check_results
        date_numbers_t got;
        date_numbers_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.first_valid   = result_ch.first_valid;
            got.second_valid  = result_ch.second_valid;
            got.doy           = result_ch.first_day_of_year;
            got.first_serial  = result_ch.first_serial;
            got.second_serial = result_ch.second_serial;
            got.diff          = result_ch.day_difference;
            got.first_later   = result_ch.first_is_later;
            if (pending_numbers.size() == 0)
                report_error($sformatf("result %0d arrived with no request pending",
                                       result_count));
            else
            begin
                want = pending_numbers.pop_front();
                compare_field("first_valid", 32'(got.first_valid), 32'(want.first_valid));
                compare_field("second_valid", 32'(got.second_valid),
                              32'(want.second_valid));
                compare_field("first_day_of_year", 32'(got.doy), 32'(want.doy));
                compare_field("first_serial", 32'(got.first_serial),
                              32'(want.first_serial));
                compare_field("second_serial", 32'(got.second_serial),
                              32'(want.second_serial));
                compare_field("day_difference", 32'(got.diff), 32'(want.diff));
                compare_field("first_is_later", 32'(got.first_later),
                              32'(want.first_later));
                if (want.first_valid && want.second_valid)
                    both_valid_count++;
                else
                    invalid_count++;
                if (want.first_later)
                    first_later_count++;
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (dates_ch.valid && !dates_ch.ready)
            input_stall_cycles++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_numbers.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_dates(mk_date(1, 1, 1), mk_date(31, 12, MAX_YEAR));
        send_dates(mk_date(31, 12, MAX_YEAR), mk_date(1, 1, 1));
        send_dates(mk_date(29, 2, 2000), mk_date(29, 2, 1900));
        send_dates(mk_date(29, 2, 2004), mk_date(29, 2, 2003));
        send_dates(mk_date(1, 3, 2000), mk_date(1, 3, 1900));
        send_dates(mk_date(31, 12, 2000), mk_date(31, 12, 2001));
        send_dates(mk_date(31, 12, 2001), mk_date(31, 12, 2000));
        send_dates(mk_date(0, 1, 2000), mk_date(1, 0, 2000));
        send_dates(mk_date(1, 13, 2000), mk_date(1, 15, 2000));
        send_dates(mk_date(1, 1, 0), mk_date(1, 1, MAX_YEAR + 1));
        send_dates(mk_date(31, 15, 16383), mk_date(0, 0, 0));
        send_dates(mk_date(31, 4, 2021), mk_date(30, 4, 2021));
        send_dates(mk_date(31, 1, 2021), mk_date(31, 1, 2021));
        send_dates(mk_date(31, 12, 1999), mk_date(1, 1, 2000));
        send_dates(mk_date(1, 1, 2000), mk_date(31, 12, 1999));
        send_dates(mk_date(28, 2, 2100), mk_date(29, 2, 2100));
        send_dates(mk_date(29, 2, 2400), mk_date(1, 1, MAX_YEAR));
        send_dates(mk_date(15, 6, 8191), mk_date(15, 6, 8192));
        send_dates(mk_date(1, 1, MAX_YEAR), mk_date(31, 12, 1));
        send_dates(mk_date(29, 2, 4), mk_date(28, 2, 1));
        send_dates(mk_date(30, 9, 1752), mk_date(31, 11, 1752));
        send_dates(mk_date(1, 1, 1), mk_date(1, 1, 1));
    endtask

    task automatic test_random_dates(int count);
        date_t a;
        repeat (count)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_idle = ~tx_idle;
            if ($urandom_range(0, 39) == 0)
                rx_idle = ~rx_idle;
            a = draw_date(1'b0);
            send_dates(a, draw_partner(a));
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // end of February and start of March around century years
    task automatic test_leap_boundaries(int count);
        date_t       a;
        int unsigned y, m, d;
        repeat (count)
        begin
            y = 100 * $urandom_range(0, 99) + $urandom_range(0, 4);
            m = $urandom_range(2, 3);
            d = (m == MONTH_FEB) ? $urandom_range(27, 30) : $urandom_range(1, 2);
            a = mk_date(d, m, y);
            send_dates(a, draw_partner(a));
        end
    endtask

    task automatic test_back_to_back(int count);
        date_t a;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count)
        begin
            a = draw_date($urandom_range(0, 3) == 0);
            send_dates(a, draw_partner(a));
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // result side holds off while requests keep coming, so the input stalls
    task automatic test_backpressure(int count);
        tx_idle = 1'b0;
        repeat (2)
        begin
            hold_off_req = 1'b1;
            repeat (count) send_dates(draw_date(1'b0), draw_date(1'b0));
        end
        tx_idle = 1'b1;
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        dates_ch.valid        <= 1'b0;
        dates_ch.first_day    <= '0;
        dates_ch.first_month  <= '0;
        dates_ch.first_year   <= '0;
        dates_ch.second_day   <= '0;
        dates_ch.second_month <= '0;
        dates_ch.second_year  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_dates(1200);
        test_leap_boundaries(250);
        test_back_to_back(300);
        test_backpressure(80);

        dates_ch.valid <= 1'b0;
        while (pending_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d date pairs: %0d fully valid,",
                 result_count, request_count, both_valid_count);
        $display("  %0d with a bad date, %0d with the first date later.",
                 invalid_count, first_later_count);
        $display("Random gaps and back-to-back runs; %0d long result holds",
                 hold_count);
        $display("  kept the input stalled for %0d cycles.", input_stall_cycles);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
